// File: rtl/core/rolling_hash_palindrome_query_defines.svh
// Assertion macros used by the hash engine top level
`ifndef ROLLING_HASH_PALINDROME_QUERY_DEFINES_SVH
`define ROLLING_HASH_PALINDROME_QUERY_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define RHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define RHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/rhpq_pkg.sv
// Types and constants of the rolling hash palindrome query engine
package rhpq_pkg;

  localparam int H1_W       = 30;
  localparam int H2_W       = 27;
  localparam int SPAN_W     = 13;
  localparam int CHAR_W     = 8;
  localparam int REQ_W      = 2;
  localparam int ST_W       = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 30;
  // multiplier operand bits, one consumed per step
  localparam int MUL_BITS   = 30;
  localparam int CNT_W      = 5;

  localparam logic [H1_W-1:0] MOD_ONE       = 30'd998244353;
  localparam logic [H1_W-1:0] EXP_ONE       = 30'd998244351;
  localparam logic [H2_W-1:0] MOD_TWO       = 27'd79020979;
  localparam logic [H2_W-1:0] EXP_TWO       = 27'd79020977;
  localparam logic [H1_W-1:0] RADIX_ONE_RST = 30'd2092427;
  localparam logic [H2_W-1:0] RADIX_TWO_RST = 27'd870083;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIX_ONE = 1'b0,
    CFG_RADIX_TWO = 1'b1
  } cfg_idx_t;

  // what the shared multipliers are working on
  typedef enum logic [1:0] {
    OP_POW = 2'd0,
    OP_APP = 2'd1,
    OP_QRY = 2'd2
  } op_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic pw_init;
    logic mul_load;
    logic mul_step;
    logic pw_update;
    logic clr_commit;
    logic app_commit;
    logic rd_sel;
    logic cap_a;
    logic cap_b;
    logic out_load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic full;
    logic bad;
    logic empty;
  } sts_t;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_DEC    = 12'b000000000010,
    S_PWINIT = 12'b000000000100,
    S_MLOAD  = 12'b000000001000,
    S_MRUN   = 12'b000000010000,
    S_PWUPD  = 12'b000000100000,
    S_CLR    = 12'b000001000000,
    S_APP    = 12'b000010000000,
    S_QA     = 12'b000100000000,
    S_QB     = 12'b001000000000,
    S_QC     = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_t;

endpackage

// File: rtl/core/rhpq_if.sv
// Valid/ready channel interfaces for requests and results
interface rhpq_in_if;
  logic                         valid;
  logic                         ready;
  logic [rhpq_pkg::REQ_W-1:0]   req_type;
  logic [rhpq_pkg::CHAR_W-1:0]  char_code;
  logic [rhpq_pkg::SPAN_W-1:0]  span_left;
  logic [rhpq_pkg::SPAN_W-1:0]  span_right;

  modport source (output valid, req_type, char_code, span_left, span_right, input ready);
  modport sink   (input valid, req_type, char_code, span_left, span_right, output ready);
endinterface

interface rhpq_out_if;
  logic                       valid;
  logic                       ready;
  logic [rhpq_pkg::H1_W-1:0]  fwd_hash_one;
  logic [rhpq_pkg::H2_W-1:0]  fwd_hash_two;
  logic [rhpq_pkg::H1_W-1:0]  rev_hash_one;
  logic [rhpq_pkg::H2_W-1:0]  rev_hash_two;
  logic                       palindrome_flag;
  logic [rhpq_pkg::ST_W-1:0]  status;

  modport source (output valid, fwd_hash_one, fwd_hash_two, rev_hash_one, rev_hash_two,
                  palindrome_flag, status, input ready);
  modport sink   (input valid, fwd_hash_one, fwd_hash_two, rev_hash_one, rev_hash_two,
                  palindrome_flag, status, output ready);
endinterface

// File: rtl/core/rolling_hash_palindrome_query.sv
// Top level of the double-modulus rolling hash palindrome query engine
//
// Takes one request transaction at a time and returns exactly one result
// transaction for it. All modular products go through bit-serial multipliers
// that consume one operand bit per cycle. An append runs one multiply pass
// before its tables are written; a query over a non-empty span makes two
// table reads, then one multiply pass for both moduli; a rejected append,
// bad or empty span or unused code goes straight from decode to the result;
// a clear runs 30 square-and-multiply rounds to form both inverse radices.
// The next request is accepted while a result still waits in the output
// register. The eight tables live in two RAMs of MAX_LEN+1 rows; there is no
// clearing pass, so issue a clear before the first append. Radix registers are
// to be written only while the block is idle; the block itself does not enforce this.
`include "rolling_hash_palindrome_query_defines.svh"

module rolling_hash_palindrome_query #(
  parameter int MAX_LEN = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rhpq_in_if.sink                         in_ch,
  rhpq_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [rhpq_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rhpq_pkg::CFG_DATA_W-1:0] cfg_data
);

  rhpq_pkg::cmd_t cmd;
  rhpq_pkg::sts_t sts;

  rhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rhpq_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_idx             (cfg_idx),
    .cfg_data            (cfg_data),
    .in_req_type         (in_ch.req_type),
    .in_char_code        (in_ch.char_code),
    .in_span_left        (in_ch.span_left),
    .in_span_right       (in_ch.span_right),
    .out_fwd_hash_one    (out_ch.fwd_hash_one),
    .out_fwd_hash_two    (out_ch.fwd_hash_two),
    .out_rev_hash_one    (out_ch.rev_hash_one),
    .out_rev_hash_two    (out_ch.rev_hash_two),
    .out_palindrome_flag (out_ch.palindrome_flag),
    .out_status          (out_ch.status)
  );

  // one request in flight at a time
  `RHPQ_ASSERT_NEXT(a_single_item, in_ch.valid && in_ch.ready, !in_ch.ready, "request taken while busy")
  // a result is never written over one not yet taken
  `RHPQ_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_ch.valid || out_ch.ready, "result overwritten")
  // a bad range carries no hash and no palindrome flag
  `RHPQ_ASSERT_NOW(a_bad_clean, out_ch.valid && out_ch.status == rhpq_pkg::ST_BAD, !out_ch.palindrome_flag && out_ch.fwd_hash_one == '0 && out_ch.rev_hash_two == '0, "bad range result not clean")

endmodule

// File: rtl/core/rhpq_ram.sv
// Generic single-write, single-read RAM with registered read data
module rhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/rhpq_modmul.sv
// Bit-serial modular multiplier: a * b mod MOD, one bit of b per step, MSB first
module rhpq_modmul #(
  parameter int             W   = 30,
  parameter logic [W-1:0]   MOD = W'(rhpq_pkg::MOD_ONE)
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          step,
  input  logic [W-1:0]                  a,      // must be below MOD
  input  logic [rhpq_pkg::MUL_BITS-1:0] b,
  output logic [W-1:0]                  res
);

  logic [W-1:0]                  acc_r, acc_nxt;
  logic [W-1:0]                  a_r;
  logic [rhpq_pkg::MUL_BITS-1:0] b_r;
  logic [W+1:0]                  t0, t1, t2;

  // acc = 2*acc + bit*a stays below 3*MOD, two conditional subtracts
  always_comb begin
    t0      = {1'b0, acc_r, 1'b0} + (b_r[rhpq_pkg::MUL_BITS-1] ? (W+2)'(a_r) : '0);
    t1      = (t0 >= (W+2)'(MOD)) ? t0 - (W+2)'(MOD) : t0;
    t2      = (t1 >= (W+2)'(MOD)) ? t1 - (W+2)'(MOD) : t1;
    acc_nxt = t2[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
    end else if (step) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[rhpq_pkg::MUL_BITS-2:0], 1'b0};
    end
  end

  assign res = acc_r;

endmodule

// File: rtl/core/rhpq_lane.sv
// Arithmetic for one modulus: tail of the tables, inverse radix, four multipliers
module rhpq_lane #(
  parameter int           W   = 30,
  parameter logic [W-1:0] MOD = W'(rhpq_pkg::MOD_ONE),
  parameter logic [W-1:0] EXP = W'(rhpq_pkg::EXP_ONE)
) (
  input  logic                        clk,
  input  rhpq_pkg::cmd_t              cmd,
  input  logic [W-1:0]                radix,
  input  logic [rhpq_pkg::CHAR_W-1:0] char_code,
  input  logic [W-1:0]                rd_fp,   // forward prefix from prefix RAM
  input  logic [W-1:0]                rd_ip,   // inverse-weighted prefix from prefix RAM
  input  logic [W-1:0]                rd_pw,   // power from power RAM
  input  logic [W-1:0]                rd_ipw,  // inverse power from power RAM
  output logic [W-1:0]                wr_fp,
  output logic [W-1:0]                wr_ip,
  output logic [W-1:0]                wr_pw,
  output logic [W-1:0]                wr_ipw,
  output logic [W-1:0]                fwd_hash,
  output logic [W-1:0]                rev_hash
);

  localparam int MB = rhpq_pkg::MUL_BITS;

  logic [W-1:0] invr_r, pw_r, ipw_r, fp_r, ip_r;
  logic [W-1:0] pm_acc_r, pm_b_r, exp_r;
  logic [W-1:0] qa_fp_r, qa_ip_r, qa_ipw_r, qb_fp_r, qb_ip_r, qb_pw_r;
  logic [W-1:0] radix_red, diff_f, diff_r;
  logic [W-1:0] mul_a   [4];
  logic [MB-1:0] mul_b  [4];
  logic [W-1:0] mul_res [4];

  function automatic logic [W-1:0] addmod(input logic [W-1:0] x, input logic [W-1:0] y);
    logic [W:0] s;
    s = (W+1)'(x) + (W+1)'(y);
    if (s >= (W+1)'(MOD)) begin
      s = s - (W+1)'(MOD);
    end
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] submod(input logic [W-1:0] x, input logic [W-1:0] y);
    logic [W:0] s;
    s = (W+1)'(x) + (W+1)'(MOD) - (W+1)'(y);
    if (s >= (W+1)'(MOD)) begin
      s = s - (W+1)'(MOD);
    end
    return s[W-1:0];
  endfunction

  // radix register may exceed the modulus, but by less than one modulus
  assign radix_red = (radix >= MOD) ? radix - MOD : radix;
  assign diff_f    = submod(qa_fp_r, qb_fp_r);
  assign diff_r    = submod(qa_ip_r, qb_ip_r);

  // operand selection for the four multipliers
  always_comb begin
    mul_a[0] = pw_r;     mul_b[0] = MB'(radix);
    mul_a[1] = ipw_r;    mul_b[1] = MB'(invr_r);
    mul_a[2] = pw_r;     mul_b[2] = MB'(char_code);
    mul_a[3] = ipw_r;    mul_b[3] = MB'(char_code);
    case (cmd.op)
      rhpq_pkg::OP_POW: begin
        mul_a[0] = pm_acc_r; mul_b[0] = MB'(pm_b_r);
        mul_a[1] = pm_b_r;   mul_b[1] = MB'(pm_b_r);
      end
      rhpq_pkg::OP_QRY: begin
        mul_a[0] = diff_f;   mul_b[0] = MB'(qa_ipw_r);
        mul_a[1] = diff_r;   mul_b[1] = MB'(qb_pw_r);
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < 4; g++) begin : g_mul
    rhpq_modmul #(.W(W), .MOD(MOD)) u_mul (
      .clk  (clk),
      .load (cmd.mul_load),
      .step (cmd.mul_step),
      .a    (mul_a[g]),
      .b    (mul_b[g]),
      .res  (mul_res[g])
    );
  end

  // next tail entry: fresh table head on clear, one position further on append
  always_comb begin
    if (cmd.clr_commit) begin
      wr_fp  = '0;
      wr_ip  = '0;
      wr_pw  = W'(1);
      wr_ipw = W'(1);
    end else begin
      wr_fp  = addmod(fp_r, mul_res[2]);
      wr_ip  = addmod(ip_r, mul_res[3]);
      wr_pw  = mul_res[0];
      wr_ipw = mul_res[1];
    end
  end

  always_ff @(posedge clk) begin
    // square-and-multiply, exponent LSB first
    if (cmd.pw_init) begin
      pm_acc_r <= W'(1);
      pm_b_r   <= radix_red;
      exp_r    <= EXP;
    end else if (cmd.pw_update) begin
      if (exp_r[0]) begin
        pm_acc_r <= mul_res[0];
      end
      pm_b_r <= mul_res[1];
      exp_r  <= exp_r >> 1;
    end
    if (cmd.clr_commit) begin
      invr_r <= pm_acc_r;
    end
    if (cmd.clr_commit || cmd.app_commit) begin
      fp_r  <= wr_fp;
      ip_r  <= wr_ip;
      pw_r  <= wr_pw;
      ipw_r <= wr_ipw;
    end
    // first read: prefixes at right, inverse power at left
    if (cmd.cap_a) begin
      qa_fp_r  <= rd_fp;
      qa_ip_r  <= rd_ip;
      qa_ipw_r <= rd_ipw;
    end
    // second read: prefixes at left, power at right - 1
    if (cmd.cap_b) begin
      qb_fp_r <= rd_fp;
      qb_ip_r <= rd_ip;
      qb_pw_r <= rd_pw;
    end
  end

  assign fwd_hash = mul_res[0];
  assign rev_hash = mul_res[1];

endmodule

// File: rtl/core/rhpq_dp.sv
// Datapath: request and config registers, table RAMs, both modulus lanes, result register
module rhpq_dp #(
  parameter int MAX_LEN = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rhpq_pkg::cmd_t                  cmd,
  output rhpq_pkg::sts_t                  sts,
  input  logic                            cfg_we,
  input  logic [rhpq_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rhpq_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [rhpq_pkg::REQ_W-1:0]      in_req_type,
  input  logic [rhpq_pkg::CHAR_W-1:0]     in_char_code,
  input  logic [rhpq_pkg::SPAN_W-1:0]     in_span_left,
  input  logic [rhpq_pkg::SPAN_W-1:0]     in_span_right,
  output logic [rhpq_pkg::H1_W-1:0]       out_fwd_hash_one,
  output logic [rhpq_pkg::H2_W-1:0]       out_fwd_hash_two,
  output logic [rhpq_pkg::H1_W-1:0]       out_rev_hash_one,
  output logic [rhpq_pkg::H2_W-1:0]       out_rev_hash_two,
  output logic                            out_palindrome_flag,
  output logic [rhpq_pkg::ST_W-1:0]       out_status
);

  localparam int H1    = rhpq_pkg::H1_W;
  localparam int H2    = rhpq_pkg::H2_W;
  localparam int DEPTH = MAX_LEN + 1;
  localparam int LEN_W = $clog2(DEPTH);
  localparam int CMP_W = (LEN_W > rhpq_pkg::SPAN_W) ? LEN_W : rhpq_pkg::SPAN_W;
  localparam int RW    = 2 * H1 + 2 * H2;

  rhpq_pkg::req_t                req_r;
  logic [rhpq_pkg::CHAR_W-1:0]   char_r;
  logic [rhpq_pkg::SPAN_W-1:0]   left_r, right_r;
  logic                          bad_r, full_r, empty_r;
  logic [LEN_W-1:0]              len_r, len_nxt;
  logic [H1-1:0]                 radix_one_r;
  logic [H2-1:0]                 radix_two_r;
  logic [CMP_W-1:0]              left_x, right_x, rm1_x, len_x;
  logic [LEN_W-1:0]              pfx_raddr, pwr_raddr, waddr;
  logic [RW-1:0]                 pfx_rdata, pwr_rdata, pfx_wdata, pwr_wdata;
  logic                          we;
  logic [H1-1:0] wfp1, wip1, wpw1, wipw1, fh1, rh1;
  logic [H2-1:0] wfp2, wip2, wpw2, wipw2, fh2, rh2;
  logic          hash_ok, pal;
  rhpq_pkg::status_t st;

  // request capture and decode flags
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= rhpq_pkg::req_t'(in_req_type);
      char_r  <= in_char_code;
      left_r  <= in_span_left;
      right_r <= in_span_right;
    end
    if (cmd.decode) begin
      bad_r   <= sts.bad;
      full_r  <= sts.full;
      empty_r <= sts.empty;
    end
  end

  assign left_x  = CMP_W'(left_r);
  assign right_x = CMP_W'(right_r);
  assign rm1_x   = right_x - CMP_W'(1);
  assign len_x   = CMP_W'(len_r);

  assign sts.req   = req_r;
  assign sts.full  = (len_r == LEN_W'(MAX_LEN));
  assign sts.bad   = (left_x > right_x) || (right_x > len_x);
  assign sts.empty = (left_x == right_x);

  // string length and radix registers
  always_comb begin
    len_nxt = len_r;
    if (cmd.clr_commit) begin
      len_nxt = '0;
    end else if (cmd.app_commit) begin
      len_nxt = len_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      radix_one_r <= rhpq_pkg::RADIX_ONE_RST;
      radix_two_r <= rhpq_pkg::RADIX_TWO_RST;
    end else begin
      len_r <= len_nxt;
      if (cfg_we && cfg_idx == rhpq_pkg::CFG_RADIX_ONE) begin
        radix_one_r <= cfg_data[H1-1:0];
      end
      if (cfg_we && cfg_idx == rhpq_pkg::CFG_RADIX_TWO) begin
        radix_two_r <= cfg_data[H2-1:0];
      end
    end
  end

  // table RAMs: prefixes in one, powers in the other
  assign pfx_raddr = cmd.rd_sel ? left_x[LEN_W-1:0] : right_x[LEN_W-1:0];
  assign pwr_raddr = cmd.rd_sel ? rm1_x[LEN_W-1:0]  : left_x[LEN_W-1:0];
  assign we        = cmd.clr_commit || cmd.app_commit;
  assign waddr     = len_nxt;
  assign pfx_wdata = {wfp1, wip1, wfp2, wip2};
  assign pwr_wdata = {wpw1, wipw1, wpw2, wipw2};

  rhpq_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_pfx_ram (
    .clk (clk), .we (we), .waddr (waddr), .wdata (pfx_wdata),
    .raddr (pfx_raddr), .rdata (pfx_rdata)
  );

  rhpq_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_pwr_ram (
    .clk (clk), .we (we), .waddr (waddr), .wdata (pwr_wdata),
    .raddr (pwr_raddr), .rdata (pwr_rdata)
  );

  rhpq_lane #(.W(H1), .MOD(rhpq_pkg::MOD_ONE), .EXP(rhpq_pkg::EXP_ONE)) u_lane_one (
    .clk       (clk),
    .cmd       (cmd),
    .radix     (radix_one_r),
    .char_code (char_r),
    .rd_fp     (pfx_rdata[RW-1 -: H1]),
    .rd_ip     (pfx_rdata[RW-H1-1 -: H1]),
    .rd_pw     (pwr_rdata[RW-1 -: H1]),
    .rd_ipw    (pwr_rdata[RW-H1-1 -: H1]),
    .wr_fp     (wfp1),
    .wr_ip     (wip1),
    .wr_pw     (wpw1),
    .wr_ipw    (wipw1),
    .fwd_hash  (fh1),
    .rev_hash  (rh1)
  );

  rhpq_lane #(.W(H2), .MOD(rhpq_pkg::MOD_TWO), .EXP(rhpq_pkg::EXP_TWO)) u_lane_two (
    .clk       (clk),
    .cmd       (cmd),
    .radix     (radix_two_r),
    .char_code (char_r),
    .rd_fp     (pfx_rdata[2*H2-1 -: H2]),
    .rd_ip     (pfx_rdata[H2-1:0]),
    .rd_pw     (pwr_rdata[2*H2-1 -: H2]),
    .rd_ipw    (pwr_rdata[H2-1:0]),
    .wr_fp     (wfp2),
    .wr_ip     (wip2),
    .wr_pw     (wpw2),
    .wr_ipw    (wipw2),
    .fwd_hash  (fh2),
    .rev_hash  (rh2)
  );

  // result formation from the flags latched at decode
  always_comb begin
    st      = rhpq_pkg::ST_OK;
    hash_ok = 1'b0;
    pal     = 1'b0;
    if (req_r == rhpq_pkg::REQ_QUERY) begin
      if (bad_r) begin
        st = rhpq_pkg::ST_BAD;
      end else if (empty_r) begin
        pal = 1'b1;
      end else begin
        hash_ok = 1'b1;
        pal     = (fh1 == rh1) && (fh2 == rh2);
      end
    end else if (req_r == rhpq_pkg::REQ_APPEND && full_r) begin
      st = rhpq_pkg::ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_fwd_hash_one    <= hash_ok ? fh1 : '0;
      out_fwd_hash_two    <= hash_ok ? fh2 : '0;
      out_rev_hash_one    <= hash_ok ? rh1 : '0;
      out_rev_hash_two    <= hash_ok ? rh2 : '0;
      out_palindrome_flag <= pal;
      out_status          <= st;
    end
  end

endmodule

// File: rtl/core/rhpq_ctrl.sv
// Controller: sequences decode, exponentiation, appends, queries and result handoff
module rhpq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  rhpq_pkg::sts_t sts,
  output rhpq_pkg::cmd_t cmd
);

  localparam int CW = rhpq_pkg::CNT_W;

  rhpq_pkg::state_t state_r, state_nxt;
  rhpq_pkg::op_t    op_r, op_nxt;
  logic [CW-1:0]    step_r, step_nxt, iter_r, iter_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last_step, last_iter;

  assign last_step = (step_r == CW'(rhpq_pkg::MUL_BITS - 1));
  assign last_iter = (iter_r == CW'(rhpq_pkg::MUL_BITS - 1));
  assign in_ready  = (state_r == rhpq_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    step_nxt  = step_r;
    iter_nxt  = iter_r;
    cmd       = '0;
    cmd.op    = op_r;
    case (state_r)
      rhpq_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = rhpq_pkg::S_DEC;
        end
      end
      rhpq_pkg::S_DEC: begin
        cmd.decode = 1'b1;
        case (sts.req)
          rhpq_pkg::REQ_CLEAR:  state_nxt = rhpq_pkg::S_PWINIT;
          rhpq_pkg::REQ_APPEND: begin
            op_nxt    = rhpq_pkg::OP_APP;
            state_nxt = sts.full ? rhpq_pkg::S_DONE : rhpq_pkg::S_MLOAD;
          end
          rhpq_pkg::REQ_QUERY: begin
            state_nxt = (sts.bad || sts.empty) ? rhpq_pkg::S_DONE : rhpq_pkg::S_QA;
          end
          default: state_nxt = rhpq_pkg::S_DONE;
        endcase
      end
      rhpq_pkg::S_PWINIT: begin
        cmd.pw_init = 1'b1;
        op_nxt      = rhpq_pkg::OP_POW;
        iter_nxt    = '0;
        state_nxt   = rhpq_pkg::S_MLOAD;
      end
      rhpq_pkg::S_MLOAD: begin
        cmd.mul_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = rhpq_pkg::S_MRUN;
      end
      rhpq_pkg::S_MRUN: begin
        cmd.mul_step = 1'b1;
        step_nxt     = step_r + CW'(1);
        if (last_step) begin
          case (op_r)
            rhpq_pkg::OP_POW: state_nxt = rhpq_pkg::S_PWUPD;
            rhpq_pkg::OP_APP: state_nxt = rhpq_pkg::S_APP;
            default:          state_nxt = rhpq_pkg::S_DONE;
          endcase
        end
      end
      rhpq_pkg::S_PWUPD: begin
        cmd.pw_update = 1'b1;
        iter_nxt      = iter_r + CW'(1);
        state_nxt     = last_iter ? rhpq_pkg::S_CLR : rhpq_pkg::S_MLOAD;
      end
      rhpq_pkg::S_CLR: begin
        cmd.clr_commit = 1'b1;
        state_nxt      = rhpq_pkg::S_DONE;
      end
      rhpq_pkg::S_APP: begin
        cmd.app_commit = 1'b1;
        state_nxt      = rhpq_pkg::S_DONE;
      end
      rhpq_pkg::S_QA: begin
        state_nxt = rhpq_pkg::S_QB;
      end
      rhpq_pkg::S_QB: begin
        cmd.rd_sel = 1'b1;
        cmd.cap_a  = 1'b1;
        state_nxt  = rhpq_pkg::S_QC;
      end
      rhpq_pkg::S_QC: begin
        cmd.cap_b = 1'b1;
        op_nxt    = rhpq_pkg::OP_QRY;
        state_nxt = rhpq_pkg::S_MLOAD;
      end
      rhpq_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = rhpq_pkg::S_IDLE;
        end
      end
      default: state_nxt = rhpq_pkg::S_IDLE;
    endcase
  end

  // result register valid: set on load, cleared when the transaction completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rhpq_pkg::S_IDLE;
      op_r        <= rhpq_pkg::OP_APP;
      step_r      <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      step_r      <= step_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: bench/rolling_hash_palindrome_query_tb.sv
// Self-checking testbench for the double-modulus rolling hash palindrome query engine
module rolling_hash_palindrome_query_tb;
  import rhpq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN = 4096;
  localparam int SETTLE  = 40;

  typedef struct packed {
    logic [H1_W-1:0] f1;
    logic [H2_W-1:0] f2;
    logic [H1_W-1:0] r1;
    logic [H2_W-1:0] r2;
    logic            pal;
    status_t         st;
  } hash_res_t;

  typedef struct {
    req_t                req;
    logic [CHAR_W-1:0]   ch;
    logic [SPAN_W-1:0]   lo;
    logic [SPAN_W-1:0]   hi;
    bit                  typed;
    hash_res_t           res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  rhpq_in_if  in_ch();
  rhpq_out_if out_ch();

  rolling_hash_palindrome_query #(.MAX_LEN(MAX_LEN)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // shadow of the engine's state
  longint unsigned base_one, base_two, inv_one, inv_two;
  int unsigned     str_len;
  longint unsigned pre1 [MAX_LEN+1], pre2 [MAX_LEN+1];
  longint unsigned ipre1 [MAX_LEN+1], ipre2 [MAX_LEN+1];
  longint unsigned pw1 [MAX_LEN+1], pw2 [MAX_LEN+1];
  longint unsigned ipw1 [MAX_LEN+1], ipw2 [MAX_LEN+1];

  hash_res_t result_q[$];
  int n_items, n_results, n_errors, n_pal, n_bad, n_full, n_clear;
  bit ready_busy;

  function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                               longint unsigned m);
    return (a * b) % m;
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                               longint unsigned m);
    longint unsigned acc;
    acc = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, b, m);
      b = mul_mod(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  // advance the shadow state by one request and return the hash result it gives
  function automatic hash_res_t hash_predict(req_t req, logic [CHAR_W-1:0] ch,
                                             int unsigned lo, int unsigned hi);
    hash_res_t r;
    int unsigned i;
    longint unsigned m1, m2, f1, f2, v1, v2;
    m1 = MOD_ONE;
    m2 = MOD_TWO;
    r = '0;
    r.st = ST_OK;
    case (req)
      REQ_CLEAR: begin
        inv_one = pow_mod(base_one, m1 - 2, m1);
        inv_two = pow_mod(base_two, m2 - 2, m2);
        str_len = 0;
        pw1[0] = 1; pw2[0] = 1; ipw1[0] = 1; ipw2[0] = 1;
        pre1[0] = 0; pre2[0] = 0; ipre1[0] = 0; ipre2[0] = 0;
      end
      REQ_APPEND: begin
        if (str_len >= MAX_LEN) begin
          r.st = ST_FULL;
        end else begin
          i = str_len;
          pw1[i+1]   = mul_mod(pw1[i], base_one % m1, m1);
          pw2[i+1]   = mul_mod(pw2[i], base_two % m2, m2);
          ipw1[i+1]  = mul_mod(ipw1[i], inv_one, m1);
          ipw2[i+1]  = mul_mod(ipw2[i], inv_two, m2);
          pre1[i+1]  = (pre1[i] + mul_mod(ch, pw1[i], m1)) % m1;
          pre2[i+1]  = (pre2[i] + mul_mod(ch, pw2[i], m2)) % m2;
          ipre1[i+1] = (ipre1[i] + mul_mod(ch, ipw1[i], m1)) % m1;
          ipre2[i+1] = (ipre2[i] + mul_mod(ch, ipw2[i], m2)) % m2;
          str_len = i + 1;
        end
      end
      REQ_QUERY: begin
        if (lo > hi || hi > str_len) begin
          r.st = ST_BAD;
        end else if (lo == hi) begin
          r.pal = 1'b1;
        end else begin
          f1 = mul_mod((pre1[hi] + m1 - pre1[lo]) % m1, ipw1[lo], m1);
          f2 = mul_mod((pre2[hi] + m2 - pre2[lo]) % m2, ipw2[lo], m2);
          v1 = mul_mod((ipre1[hi] + m1 - ipre1[lo]) % m1, pw1[hi-1], m1);
          v2 = mul_mod((ipre2[hi] + m2 - ipre2[lo]) % m2, pw2[hi-1], m2);
          r.f1 = f1; r.f2 = f2; r.r1 = v1; r.r2 = v2;
          r.pal = (f1 == v1) && (f2 == v2);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("rolling_hash_palindrome_query_tb failed");
    $finish;
  end

  // result side back-pressure: short and occasional long stalls, with quiet stretches
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b1;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (ready_busy && $urandom_range(0, 99) < 25) begin
      out_ch.ready <= 1'b0;
      stall_left   <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                   : $urandom_range(0, 3);
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 299) == 0) ready_busy <= ~ready_busy;
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    hash_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (result_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result transaction", $time);
      end else begin
        e = result_q.pop_front();
        if (out_ch.fwd_hash_one !== e.f1 || out_ch.fwd_hash_two !== e.f2 ||
            out_ch.rev_hash_one !== e.r1 || out_ch.rev_hash_two !== e.r2 ||
            out_ch.palindrome_flag !== e.pal || out_ch.status !== e.st) begin
          n_errors++;
          $display("%0t: mismatch expected f=%0d/%0d r=%0d/%0d pal=%0b st=%0d", $time,
                   e.f1, e.f2, e.r1, e.r2, e.pal, e.st);
          $display("%0t:          actual f=%0d/%0d r=%0d/%0d pal=%0b st=%0d", $time,
                   out_ch.fwd_hash_one, out_ch.fwd_hash_two, out_ch.rev_hash_one,
                   out_ch.rev_hash_two, out_ch.palindrome_flag, out_ch.status);
        end
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one request and hold it until the engine takes it
  task automatic send_req(req_t req, logic [CHAR_W-1:0] ch, logic [SPAN_W-1:0] lo,
                          logic [SPAN_W-1:0] hi, bit typed, hash_res_t typed_res,
                          int gap);
    hash_res_t p;
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.char_code  <= ch;
    in_ch.span_left  <= lo;
    in_ch.span_right <= hi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    p = hash_predict(req, ch, lo, hi);
    result_q.push_back(typed ? typed_res : p);
    n_items++;
    if (req == REQ_CLEAR) n_clear++;
    if (p.st == ST_BAD) n_bad++;
    if (p.st == ST_FULL) n_full++;
    if (req == REQ_QUERY && p.pal && lo != hi) n_pal++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_pred(req_t req, int unsigned ch, int unsigned lo,
                           int unsigned hi, int gap);
    send_req(req, CHAR_W'(ch), SPAN_W'(lo), SPAN_W'(hi), 1'b0, '0, gap);
  endtask

  // hold off until every expected result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_radix(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_RADIX_ONE) base_one = val[H1_W-1:0];
    else base_two = val[H2_W-1:0];
  endtask

  function automatic stim_row_t row(req_t req, int ch, int lo, int hi, bit typed,
                                    status_t st, bit pal);
    stim_row_t s;
    s.req = req; s.ch = CHAR_W'(ch); s.lo = SPAN_W'(lo); s.hi = SPAN_W'(hi);
    s.typed = typed;
    s.res = '0;
    s.res.st = st;
    s.res.pal = pal;
    return s;
  endfunction

  // random part: one configuration phase
  task automatic random_phase(int count);
    int k, p, n, lo, hi;
    logic [CHAR_W-1:0] pal_s [8];
    for (k = 0; k < count; k++) begin
      p = $urandom_range(0, 99);
      if (p < 1) begin
        send_pred(REQ_CLEAR, $urandom, $urandom, $urandom, pick_gap());
      end else if (p < 42) begin
        send_pred(REQ_APPEND, $urandom_range(0, 255), $urandom, $urandom, pick_gap());
      end else if (p < 47) begin
        // mirrored run, then query across it
        n = $urandom_range(1, 8);
        lo = str_len;
        for (int j = 0; j < n; j++) pal_s[j] = $urandom_range(0, 3) * 85;
        for (int j = 0; j < n; j++) pal_s[n-1-j] = pal_s[j];
        for (int j = 0; j < n; j++) send_pred(REQ_APPEND, pal_s[j], 0, 0, pick_gap());
        send_pred(REQ_QUERY, $urandom, lo, lo + n, pick_gap());
        k += n;
      end else if (p < 88) begin
        hi = $urandom_range(0, str_len);
        lo = ($urandom_range(0, 9) == 0) ? hi : $urandom_range(0, hi);
        send_pred(REQ_QUERY, $urandom, lo, hi, pick_gap());
      end else if (p < 95) begin
        send_pred(REQ_QUERY, $urandom, $urandom_range(0, 8191), $urandom_range(0, 8191),
                  pick_gap());
      end else if (p < 98) begin
        send_pred(REQ_NONE, $urandom, $urandom, $urandom, pick_gap());
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    stim_row_t dir_rows[$];
    logic [CFG_DATA_W-1:0] r1_set [5];
    logic [CFG_DATA_W-1:0] r2_set [5];
    n_items = 0; n_results = 0; n_errors = 0; n_pal = 0;
    n_bad = 0; n_full = 0; n_clear = 0;
    ready_busy = 1'b1;
    base_one = RADIX_ONE_RST;
    base_two = RADIX_TWO_RST;
    inv_one = 0; inv_two = 0; str_len = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = CFG_RADIX_ONE; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.req_type = REQ_NONE; in_ch.char_code = '0;
    in_ch.span_left = '0; in_ch.span_right = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: typed rows are the trivially known results
    dir_rows.push_back(row(REQ_QUERY, 0, 0, 0, 1, ST_OK, 1));
    dir_rows.push_back(row(REQ_QUERY, 0, 0, 1, 1, ST_BAD, 0));
    dir_rows.push_back(row(REQ_NONE, 255, 8191, 8191, 1, ST_OK, 0));
    dir_rows.push_back(row(REQ_CLEAR, 0, 0, 0, 1, ST_OK, 0));
    dir_rows.push_back(row(REQ_APPEND, 0, 0, 0, 1, ST_OK, 0));
    dir_rows.push_back(row(REQ_APPEND, 255, 8191, 8191, 1, ST_OK, 0));
    dir_rows.push_back(row(REQ_APPEND, 97, 0, 0, 1, ST_OK, 0));
    dir_rows.push_back(row(REQ_APPEND, 255, 0, 0, 1, ST_OK, 0));
    dir_rows.push_back(row(REQ_APPEND, 0, 0, 0, 1, ST_OK, 0));
    dir_rows.push_back(row(REQ_QUERY, 0, 0, 5, 0, ST_OK, 0));
    dir_rows.push_back(row(REQ_QUERY, 0, 1, 4, 0, ST_OK, 0));
    dir_rows.push_back(row(REQ_QUERY, 255, 0, 4, 0, ST_OK, 0));
    dir_rows.push_back(row(REQ_QUERY, 0, 2, 3, 0, ST_OK, 0));
    dir_rows.push_back(row(REQ_QUERY, 0, 5, 5, 1, ST_OK, 1));
    dir_rows.push_back(row(REQ_QUERY, 0, 6, 6, 1, ST_BAD, 0));
    dir_rows.push_back(row(REQ_QUERY, 0, 3, 2, 1, ST_BAD, 0));
    dir_rows.push_back(row(REQ_QUERY, 0, 8191, 8191, 1, ST_BAD, 0));
    dir_rows.push_back(row(REQ_QUERY, 0, 0, 8191, 1, ST_BAD, 0));
    dir_rows.push_back(row(REQ_NONE, 0, 1, 2, 1, ST_OK, 0));
    dir_rows.push_back(row(REQ_CLEAR, 9, 9, 9, 1, ST_OK, 0));
    dir_rows.push_back(row(REQ_APPEND, 1, 0, 0, 1, ST_OK, 0));
    dir_rows.push_back(row(REQ_QUERY, 0, 0, 1, 0, ST_OK, 0));
    foreach (dir_rows[i])
      send_req(dir_rows[i].req, dir_rows[i].ch, dir_rows[i].lo, dir_rows[i].hi,
               dir_rows[i].typed, dir_rows[i].res, pick_gap());
    drain();

    // configuration phases, extremes first; odd phases keep the string so the
    // old inverse radix meets the new radix
    r1_set[0] = RADIX_ONE_RST; r2_set[0] = RADIX_TWO_RST;
    r1_set[1] = 1;             r2_set[1] = 1;
    r1_set[2] = 998244352;     r2_set[2] = 79020978;
    r1_set[3] = $urandom_range(2, 998244351);
    r2_set[3] = $urandom_range(2, 79020977);
    r1_set[4] = $urandom_range(2, 998244351);
    r2_set[4] = $urandom_range(2, 79020977);
    for (int ph = 0; ph < 5; ph++) begin
      write_radix(CFG_RADIX_ONE, r1_set[ph]);
      write_radix(CFG_RADIX_TWO, r2_set[ph]);
      cfg_we <= 1'b0;
      @(posedge clk);
      if (ph % 2 == 0) send_pred(REQ_CLEAR, 0, 0, 0, pick_gap());
      random_phase(320);
      drain();
    end

    // spans at the far end of the table address range
    send_pred(REQ_QUERY, 0, 0, str_len, pick_gap());
    send_pred(REQ_QUERY, 0, 0, MAX_LEN, pick_gap());
    send_pred(REQ_QUERY, 0, MAX_LEN, MAX_LEN, pick_gap());
    send_pred(REQ_QUERY, 0, 4095 - 7, 4095, pick_gap());
    send_pred(REQ_QUERY, 0, 0, MAX_LEN + 1, pick_gap());
    drain();

    $display("covered %0d requests (%0d clears), %0d results, %0d non-trivial palindromes,",
             n_items, n_clear, n_results, n_pal);
    $display("%0d bad spans and %0d appends dropped on a full string, 5 radix settings",
             n_bad, n_full);
    if (n_errors == 0 && result_q.size() == 0) begin
      $display("rolling_hash_palindrome_query_tb passed");
    end else begin
      $display("rolling_hash_palindrome_query_tb failed");
    end
    $finish;
  end

endmodule
